// ===== src/stk_pkg.sv =====
// shared types and constants for the sorted top-k score table
package stk_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CMD_W        = 2;
	localparam int KEY_W        = 16;
	localparam int SCORE_W      = 32;
	localparam int IDX_W        = 4;
	localparam int STATUS_W     = 3;
	localparam int POS_W        = 4;
	localparam int COUNT_W      = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_IGNORED  = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_READ     = 3'd4,
		ST_BADIDX   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_UPDATE,
		OP_REMOVE
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_UPD
	} phase_t;

	typedef struct packed {
		logic                      valid;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic                      cmp_en;
		logic                      upd_en;
		op_t                       op;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [IDX_W-1:0]          idx;
	} cell_ctl_t;

endpackage

// ===== src/sorted_top_k_score_table.sv =====
// top level: command sequencer over a row of score table cells
// a transaction accepted at a clock edge runs a compare pass, then a shift pass; done is registered from the shift pass
// a new transaction is taken only after the compare pass and the shift pass, once the sequencer is back in idle
// busy is high through the compare and shift passes after acceptance; the result receiver cannot stall
// reset clears the entry count and every slot's valid bit; slot contents stay undefined
module sorted_top_k_score_table #(
	parameter int CAPACITY = stk_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [stk_pkg::CMD_W-1:0]        cmd,
	input  logic [stk_pkg::KEY_W-1:0]        player_key,
	input  logic signed [stk_pkg::SCORE_W-1:0] new_score,
	input  logic [stk_pkg::IDX_W-1:0]        slot_index,
	output logic                             done,
	output logic [stk_pkg::STATUS_W-1:0]     status,
	output logic [stk_pkg::KEY_W-1:0]        out_key,
	output logic signed [stk_pkg::SCORE_W-1:0] out_score,
	output logic [stk_pkg::POS_W-1:0]        final_position,
	output logic [stk_pkg::COUNT_W-1:0]      entry_count
);
	import stk_pkg::*;

	localparam int CW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	phase_t                    phase_q;
	phase_t                    phase_d;
	logic                      cmp_en;
	logic                      upd_en;
	logic                      accept;

	cmd_t                      cmd_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [IDX_W-1:0]          idx_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cnt_d;

	logic [KEY_W-1:0]          rd_key_c;
	logic signed [SCORE_W-1:0] rd_score_c;
	logic [KEY_W-1:0]          rd_key_s1;
	logic signed [SCORE_W-1:0] rd_score_s1;

	cell_ctl_t                 ctl;
	op_t                       op_c;
	status_t                   status_c;
	logic [KEY_W-1:0]          okey_c;
	logic signed [SCORE_W-1:0] oscore_c;
	logic                      use_pos;
	logic [CW-1:0]             pos_acc;
	logic [CW-1:0]             pos_c;
	logic [CW+POS_W-1:0]       pos_wide;
	logic [CNT_W+COUNT_W-1:0]  cnt_wide;
	logic                      found;
	logic                      upd_any;
	logic                      take;
	logic                      full;
	logic                      bad_idx;

	logic                      done_q;
	status_t                   status_q;
	logic [KEY_W-1:0]          okey_q;
	logic signed [SCORE_W-1:0] oscore_q;
	logic [POS_W-1:0]          pos_q;
	logic [COUNT_W-1:0]        ecount_q;

	entry_t                    ents      [CAPACITY];
	entry_t                    prev_ents [CAPACITY];
	entry_t                    next_ents [CAPACITY];
	logic [CAPACITY-1:0]       prev_ge_v;
	logic [CAPACITY-1:0]       ge_v;
	logic [CAPACITY-1:0]       match_v;
	logic [CAPACITY-1:0]       updok_v;
	logic [CAPACITY-1:0]       target_v;
	logic [CAPACITY-1:0]       valid_v;
	logic [CAPACITY:0]         pre_c;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_IDLE: phase_d = start ? PH_CMP : PH_IDLE;
			PH_CMP:  phase_d = PH_UPD;
			PH_UPD:  phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		cmp_en = 1'b0;
		upd_en = 1'b0;
		unique case (phase_q)
			PH_IDLE: busy = 1'b0;
			PH_CMP:  cmp_en = 1'b1;
			PH_UPD:  upd_en = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_NONE;
		end else if (accept) begin
			cmd_q <= cmd_t'(cmd);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= player_key;
			score_q <= new_score;
			idx_q   <= slot_index;
		end
	end

	// cell row
	assign pre_c[0] = 1'b0;

	genvar g;
	for (g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prev_ents[g] = '0;
			assign prev_ge_v[g] = 1'b1;
		end else begin : g_body
			assign prev_ents[g] = ents[g-1];
			assign prev_ge_v[g] = ge_v[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign next_ents[g] = '0;
		end else begin : g_link
			assign next_ents[g] = ents[g+1];
		end

		stk_cell #(
			.IDX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev_ent (prev_ents[g]),
			.prev_ge  (prev_ge_v[g]),
			.next_ent (next_ents[g]),
			.pre_in   (pre_c[g]),
			.pre_out  (pre_c[g+1]),
			.ent      (ents[g]),
			.ge       (ge_v[g]),
			.match    (match_v[g]),
			.upd_ok   (updok_v[g]),
			.target   (target_v[g])
		);

		assign valid_v[g] = ents[g].valid;
	end

	always_comb begin
		ctl.cmp_en = cmp_en;
		ctl.upd_en = upd_en;
		ctl.op     = op_c;
		ctl.key    = key_q;
		ctl.score  = score_q;
		ctl.idx    = idx_q;
	end

	// entry at slot_index, taken during the compare pass
	always_comb begin
		rd_key_c   = '0;
		rd_score_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (32'(idx_q) == i) begin
				rd_key_c   = ents[i].key;
				rd_score_c = ents[i].score;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			rd_key_s1   <= rd_key_c;
			rd_score_s1 <= rd_score_c;
		end
	end

	assign found   = |match_v;
	assign upd_any = |updok_v;
	assign take    = !ge_v[CAPACITY-1];
	assign full    = 32'(cnt_q) >= 32'(CAPACITY);
	assign bad_idx = 32'(idx_q) >= 32'(cnt_q);

	always_comb begin
		pos_acc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (target_v[i]) begin
				pos_acc = pos_acc | CW'(i);
			end
		end
	end

	// decision for the shift pass
	always_comb begin
		op_c     = OP_HOLD;
		status_c = ST_IGNORED;
		okey_c   = '0;
		oscore_c = '0;
		use_pos  = 1'b0;
		cnt_d    = cnt_q;
		unique case (cmd_q)
			CMD_ADD: begin
				if (found) begin
					if (upd_any) begin
						op_c     = OP_UPDATE;
						status_c = ST_UPDATED;
						use_pos  = 1'b1;
					end
				end else if (take) begin
					op_c     = OP_INSERT;
					status_c = ST_INSERTED;
					use_pos  = 1'b1;
					if (!full) begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			CMD_REMOVE, CMD_READ: begin
				if (bad_idx) begin
					status_c = ST_BADIDX;
				end else begin
					okey_c   = rd_key_s1;
					oscore_c = rd_score_s1;
					if (cmd_q == CMD_REMOVE) begin
						op_c     = OP_REMOVE;
						status_c = ST_REMOVED;
						cnt_d    = cnt_q - CNT_W'(1);
					end else begin
						status_c = ST_READ;
					end
				end
			end
			CMD_NONE: begin
			end
		endcase
	end

	assign pos_c    = use_pos ? pos_acc : '0;
	assign pos_wide = (CW + POS_W)'(pos_c);
	assign cnt_wide = (CNT_W + COUNT_W)'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= upd_en;
			if (upd_en) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			status_q <= status_c;
			okey_q   <= okey_c;
			oscore_q <= oscore_c;
			pos_q    <= pos_wide[POS_W-1:0];
			ecount_q <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_key        = okey_q;
	assign out_score      = oscore_q;
	assign final_position = pos_q;
	assign entry_count    = ecount_q;

`ifndef SYNTHESIS
	a_done_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(phase_q) == PH_UPD))
		else $error("result strobe without a shift pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(CAPACITY))
		else $error("entry count above capacity");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(cnt_q))
		else $error("slot valid bits disagree with entry count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && cmp_en))
		else $error("transaction accepted but compare pass missing");
`endif

endmodule

// ===== src/stk_cell.sv =====
// one table slot: holds an entry, compares it to the transaction, shifts with its neighbors
module stk_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stk_pkg::cell_ctl_t ctl,
	input  stk_pkg::entry_t   prev_ent,
	input  logic              prev_ge,
	input  stk_pkg::entry_t   next_ent,
	input  logic              pre_in,
	output logic              pre_out,
	output stk_pkg::entry_t   ent,
	output logic              ge,
	output logic              match,
	output logic              upd_ok,
	output logic              target
);
	import stk_pkg::*;

	logic                      valid_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      match_s1;
	logic                      ge_s1;
	logic                      le_s1;
	logic                      target_c;
	logic                      shift_c;
	logic                      pull_c;

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.score = score_q;
	assign ge        = ge_s1;
	assign match     = match_s1;
	assign upd_ok    = match_s1 & le_s1;
	assign pre_out   = pre_in | match_s1;
	assign target    = target_c;

	// compare pass
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_s1 <= valid_q && (key_q == ctl.key);
			ge_s1    <= valid_q && ($signed(score_q) >= $signed(ctl.score));
			le_s1    <= $signed(score_q) <= $signed(ctl.score);
		end
	end

	// pre_in: the matching key sits strictly above this slot
	always_comb begin
		target_c = 1'b0;
		shift_c  = 1'b0;
		pull_c   = 1'b0;
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_INSERT: begin
				target_c = !ge_s1 && prev_ge;
				shift_c  = !prev_ge;
			end
			OP_UPDATE: begin
				target_c = !pre_in && (match_s1 || !ge_s1) && prev_ge;
				shift_c  = !pre_in && !prev_ge;
			end
			OP_REMOVE: begin
				pull_c = 32'(ctl.idx) <= 32'(IDX);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd_en) begin
			priority if (target_c) begin
				valid_q <= 1'b1;
			end else if (shift_c) begin
				valid_q <= prev_ent.valid;
			end else if (pull_c) begin
				valid_q <= next_ent.valid;
			end else begin
				valid_q <= valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			priority if (target_c) begin
				key_q   <= ctl.key;
				score_q <= ctl.score;
			end else if (shift_c) begin
				key_q   <= prev_ent.key;
				score_q <= prev_ent.score;
			end else if (pull_c) begin
				key_q   <= next_ent.key;
				score_q <= next_ent.score;
			end else begin
				key_q   <= key_q;
				score_q <= score_q;
			end
		end
	end

endmodule

// ===== tb/sorted_top_k_score_table_test.sv =====
// testbench for the sorted top-k score table: directed and random commands against a predictor
`timescale 1ns / 100ps

import stk_pkg::*;

typedef struct {
	status_t                   status;
	logic [KEY_W-1:0]          key;
	logic signed [SCORE_W-1:0] score;
	logic [POS_W-1:0]          pos;
	logic [COUNT_W-1:0]        count;
} outcome_t;

class ranking_checker;
	localparam int DEPTH = CAPACITY_DEF;

	logic [KEY_W-1:0]          slot_key [DEPTH];
	logic signed [SCORE_W-1:0] slot_score [DEPTH];
	int                        fill;
	outcome_t                  pending_outcomes [$];
	int                        fails;
	int                        seen_status [6];
	int                        seen_full;
	int                        checked;

	function new();
		fill = 0;
		fails = 0;
		seen_full = 0;
		checked = 0;
		foreach (slot_key[i]) begin
			slot_key[i] = '0;
			slot_score[i] = '0;
		end
		foreach (seen_status[i])
			seen_status[i] = 0;
	endfunction

	function int pending();
		return pending_outcomes.size();
	endfunction

	function int entries();
		return fill;
	endfunction

	function logic signed [SCORE_W-1:0] score_at(int i);
		return slot_score[i];
	endfunction

	// works out the outcome of one accepted transaction and updates the table copy
	function void note_command(cmd_t op, logic [KEY_W-1:0] k, logic signed [SCORE_W-1:0] s,
			logic [IDX_W-1:0] idx);
		outcome_t                  o;
		int                        found;
		int                        i;
		int                        n;
		bit                        take;
		logic [KEY_W-1:0]          tk;
		logic signed [SCORE_W-1:0] ts;
		o.status = ST_IGNORED;
		o.key = '0;
		o.score = '0;
		o.pos = '0;
		case (op)
			CMD_ADD: begin
				found = fill;
				for (i = 0; i < fill; i++)
					if (slot_key[i] == k) begin
						found = i;
						break;
					end
				if (found < fill) begin
					if (slot_score[found] <= s) begin
						slot_score[found] = s;
						i = found;
						// climb past every strictly lower score
						while (i > 0 && slot_score[i] > slot_score[i-1]) begin
							tk = slot_key[i];
							ts = slot_score[i];
							slot_key[i] = slot_key[i-1];
							slot_score[i] = slot_score[i-1];
							slot_key[i-1] = tk;
							slot_score[i-1] = ts;
							i--;
						end
						o.status = ST_UPDATED;
						o.pos = i[POS_W-1:0];
					end
				end else begin
					take = 1'b1;
					if (fill >= DEPTH) begin
						n = DEPTH;
						if (s <= slot_score[DEPTH-1])
							take = 1'b0;
					end else
						n = fill + 1;
					if (take) begin
						fill = n;
						i = n - 1;
						// new key lands after equal scores
						while (i > 0 && s > slot_score[i-1]) begin
							slot_key[i] = slot_key[i-1];
							slot_score[i] = slot_score[i-1];
							i--;
						end
						slot_key[i] = k;
						slot_score[i] = s;
						o.status = ST_INSERTED;
						o.pos = i[POS_W-1:0];
					end
				end
			end
			CMD_REMOVE, CMD_READ: begin
				if (int'(idx) >= fill)
					o.status = ST_BADIDX;
				else begin
					o.key = slot_key[idx];
					o.score = slot_score[idx];
					if (op == CMD_REMOVE) begin
						for (i = int'(idx) + 1; i < fill; i++) begin
							slot_key[i-1] = slot_key[i];
							slot_score[i-1] = slot_score[i];
						end
						fill--;
						o.status = ST_REMOVED;
					end else
						o.status = ST_READ;
				end
			end
			default: ;
		endcase
		o.count = fill[COUNT_W-1:0];
		pending_outcomes.push_back(o);
	endfunction

	function void check_outcome(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
			logic signed [SCORE_W-1:0] s, logic [POS_W-1:0] p, logic [COUNT_W-1:0] c);
		outcome_t o;
		if (pending_outcomes.size() == 0) begin
			$error("result with no transaction waiting: status %0d", st);
			fails++;
			return;
		end
		o = pending_outcomes.pop_front();
		checked++;
		if (st < 6)
			seen_status[st]++;
		if (c == COUNT_W'(DEPTH))
			seen_full++;
		if (st !== o.status) begin
			$error("status: expected %0d, got %0d", o.status, st);
			fails++;
		end
		if (k !== o.key) begin
			$error("out_key: expected %0h, got %0h", o.key, k);
			fails++;
		end
		if (s !== o.score) begin
			$error("out_score: expected %0d, got %0d", o.score, s);
			fails++;
		end
		if (p !== o.pos) begin
			$error("final_position: expected %0d, got %0d", o.pos, p);
			fails++;
		end
		if (c !== o.count) begin
			$error("entry_count: expected %0d, got %0d", o.count, c);
			fails++;
		end
	endfunction
endclass

module sorted_top_k_score_table_test;

	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 200000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [CMD_W-1:0]           cmd = '0;
	logic [KEY_W-1:0]           player_key = '0;
	logic signed [SCORE_W-1:0]  new_score = '0;
	logic [IDX_W-1:0]           slot_index = '0;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic [KEY_W-1:0]           out_key;
	logic signed [SCORE_W-1:0]  out_score;
	logic [POS_W-1:0]           final_position;
	logic [COUNT_W-1:0]         entry_count;

	ranking_checker             sb;
	int                         cycles = 0;
	logic [KEY_W-1:0]           key_pool [24];

	sorted_top_k_score_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.player_key     (player_key),
		.new_score      (new_score),
		.slot_index     (slot_index),
		.done           (done),
		.status         (status),
		.out_key        (out_key),
		.out_score      (out_score),
		.final_position (final_position),
		.entry_count    (entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	// sample both sides at the edge, before the block's own updates land
	always @(posedge clk) begin
		if (done)
			sb.check_outcome(status, out_key, out_score, final_position, entry_count);
		if (arst_n && start && !busy)
			sb.note_command(cmd_t'(cmd), player_key, new_score, slot_index);
	end

	// call only right after a rising edge; returns at the edge that takes the transaction
	task automatic issue(cmd_t op, logic [KEY_W-1:0] k, logic signed [SCORE_W-1:0] s,
			logic [IDX_W-1:0] idx);
		start <= 1'b1;
		cmd <= op;
		player_key <= k;
		new_score <= s;
		slot_index <= idx;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		int                        r;
		cmd_t                      op;
		logic [KEY_W-1:0]          k;
		logic signed [SCORE_W-1:0] s;
		logic [IDX_W-1:0]          idx;
		r = $urandom_range(0, 99);
		if (r < 52)
			op = CMD_ADD;
		else if (r < 70)
			op = CMD_REMOVE;
		else if (r < 95)
			op = CMD_READ;
		else
			op = CMD_NONE;
		// a small key pool makes updates of known keys common
		if ($urandom_range(0, 99) < 70)
			k = key_pool[$urandom_range(0, 23)];
		else
			k = KEY_W'($urandom());
		r = $urandom_range(0, 99);
		if (r < 45)
			s = $signed(32'($urandom_range(0, 60))) - 30;
		else if (r < 65 && sb.entries() > 0)
			s = sb.score_at($urandom_range(0, sb.entries() - 1));
		else if (r < 88)
			s = $signed($urandom());
		else
			case ($urandom_range(0, 3))
				0: s = 32'sh7fffffff;
				1: s = 32'sh80000000;
				2: s = -1;
				default: s = 32'sh7ffffffe;
			endcase
		if ($urandom_range(0, 99) < 70 && sb.entries() > 0)
			idx = IDX_W'($urandom_range(0, sb.entries() - 1));
		else
			idx = IDX_W'($urandom());
		issue(op, k, s, idx);
	endtask

	initial begin
		int sent;
		int burst;
		sb = new();
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom());
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused command, extremes of key and score
		issue(CMD_READ, 16'h0000, 0, 4'd0);
		issue(CMD_REMOVE, 16'h0000, 0, 4'd15);
		issue(CMD_NONE, 16'hffff, -1, 4'd15);
		issue(CMD_ADD, 16'h0000, 0, 4'd0);
		issue(CMD_ADD, 16'hffff, 32'sh7fffffff, 4'd0);
		issue(CMD_ADD, 16'h1234, 32'sh80000000, 4'd0);
		// new key with a tied score goes after the existing one
		issue(CMD_ADD, 16'h0042, 0, 4'd0);
		// tied update, lower update, then an update that climbs
		issue(CMD_ADD, 16'h0000, 0, 4'd0);
		issue(CMD_ADD, 16'h0000, -5, 4'd0);
		issue(CMD_ADD, 16'h1234, 100, 4'd0);
		issue(CMD_READ, 16'h0000, 0, 4'd1);
		issue(CMD_REMOVE, 16'h0000, 0, 4'd0);
		pause(3);
		// fill up to capacity with falling scores
		for (int i = 0; i < CAPACITY_DEF - 3; i++)
			issue(CMD_ADD, KEY_W'(16'h0100 + i), -100 - 10 * i, 4'd0);
		// full table: tied low score is dropped, a higher one pushes out the last
		issue(CMD_ADD, 16'hbeef, -100 - 10 * (CAPACITY_DEF - 4), 4'd0);
		issue(CMD_ADD, 16'hcafe, 50, 4'd0);
		issue(CMD_READ, 16'h0000, 0, 4'd15);
		issue(CMD_REMOVE, 16'h0000, 0, 4'd15);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
				random_item();
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					drain();
			end
			// about a quarter of bursts run straight into the next
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 8));
		end
		drain();
		repeat (4) @(posedge clk);

		$display("checked %0d results: %0d inserted, %0d updated, %0d ignored, %0d removed,",
			sb.checked, sb.seen_status[ST_INSERTED], sb.seen_status[ST_UPDATED],
			sb.seen_status[ST_IGNORED], sb.seen_status[ST_REMOVED]);
		$display("%0d read, %0d bad index; table full after %0d of them",
			sb.seen_status[ST_READ], sb.seen_status[ST_BADIDX], sb.seen_full);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/stk_pkg.sv
src/stk_cell.sv
src/sorted_top_k_score_table.sv
tb/sorted_top_k_score_table_test.sv
